@@ rtl/ppdrain_pkg.sv @@
`default_nettype none

package ppdrain_pkg;

    // Buffer geometry: two halves of HALF_BYTES each, drained in chunks.
    localparam int unsigned HALF_BYTES  = 4096;
    localparam int unsigned CYCLE_BYTES = 2 * HALF_BYTES;
    localparam int unsigned CHUNK_BYTES = 1024;

    // Field widths of the register snapshot and the result.
    localparam int unsigned PTR_W  = 14;
    localparam int unsigned LEN_W  = 13;
    localparam int unsigned ADDR_W = 13;
    localparam int unsigned MODE_W = 2;

    // Read offset runs modulo CYCLE_BYTES; its top bit selects the half.
    localparam int unsigned OFF_W  = $clog2(CYCLE_BYTES);
    localparam int unsigned HOFF_W = $clog2(HALF_BYTES);

    // Receiver state codes.
    localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LISTEN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OVERFLOW = 2'd2;

    // Register write ordered with each result.
    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_SETUP    = 2'd1,
        ACT_OVERFLOW = 2'd2,
        ACT_REFILL   = 2'd3
    } write_action_t;

    // One snapshot of the receiver's double-buffer registers.
    typedef struct packed {
        logic [PTR_W-1:0]  prime_ptr;
        logic [LEN_W-1:0]  prime_len;
        logic [PTR_W-1:0]  alt_ptr;
        logic [LEN_W-1:0]  alt_len;
        logic [MODE_W-1:0] rx_mode;
    } rx_snap_t;

    // Read runs and register write-back for one snapshot.
    typedef struct packed {
        logic [ADDR_W-1:0] read_addr;
        logic [LEN_W-1:0]  run_len;
        logic [ADDR_W-1:0] flip_addr;
        logic [LEN_W-1:0]  flip_len;
        write_action_t     write_action;
        logic [PTR_W-1:0]  new_prime_ptr;
        logic [LEN_W-1:0]  new_prime_len;
        logic [PTR_W-1:0]  new_alt_ptr;
        logic [LEN_W-1:0]  new_alt_len;
        logic [MODE_W-1:0] new_rx_mode;
        logic              snapshot_fault;
    } drain_res_t;

    // Read offset update produced alongside each result.
    typedef struct packed {
        logic             load;
        logic [OFF_W-1:0] value;
    } off_upd_t;

endpackage

`default_nettype wire

@@ rtl/ppdrain_calc.sv @@
`default_nettype none

module ppdrain_calc (
    input  ppdrain_pkg::rx_snap_t   snap,
    input  logic [ppdrain_pkg::OFF_W-1:0] offset,
    output ppdrain_pkg::drain_res_t res,
    output ppdrain_pkg::off_upd_t   off_upd
);
    import ppdrain_pkg::*;

    localparam int unsigned SUM_W = PTR_W + 1;

    logic [SUM_W-1:0]  end_p;
    logic [SUM_W-1:0]  end_a;
    logic              p_h1;
    logic              alt_armed;
    logic              rhalf;
    logic [HOFF_W-1:0] rho;
    logic [PTR_W-1:0]  rbase;
    logic [PTR_W-1:0]  obase;
    logic [PTR_W-1:0]  nbase;
    logic [SUM_W-1:0]  diff_o;
    logic [SUM_W-1:0]  diff_r;
    logic              geom_fault;
    logic              pos_fault;
    logic [PTR_W-1:0]  len_raw;
    logic [PTR_W-1:0]  flen_raw;
    logic [PTR_W-1:0]  run_sum;
    logic [PTR_W-1:0]  len;
    logic [PTR_W-1:0]  flen;
    logic [OFF_W-1:0]  noff;
    logic              unread;
    logic              fault;
    write_action_t     action;

    // Region ends and which half the prime region sits in.
    assign end_p     = {1'b0, snap.prime_ptr} + SUM_W'(snap.prime_len);
    assign end_a     = {1'b0, snap.alt_ptr} + SUM_W'(snap.alt_len);
    assign p_h1      = (end_p == SUM_W'(CYCLE_BYTES));
    assign alt_armed = (end_a != '0);

    // Current read position split into half and position within the half.
    assign rhalf = offset[OFF_W-1];
    assign rho   = offset[HOFF_W-1:0];
    assign rbase = rhalf ? PTR_W'(HALF_BYTES) : '0;
    assign obase = rhalf ? '0 : PTR_W'(HALF_BYTES);
    assign nbase = p_h1 ? '0 : PTR_W'(HALF_BYTES);

    assign diff_o = {1'b0, snap.prime_ptr} - {1'b0, obase};
    assign diff_r = {1'b0, snap.prime_ptr} - {1'b0, rbase};

    // The prime end and any armed alternate end must sit on half boundaries and differ.
    assign geom_fault = (end_p != SUM_W'(HALF_BYTES) && end_p != SUM_W'(CYCLE_BYTES))
                     || (end_p == end_a)
                     || (alt_armed && end_a != SUM_W'(HALF_BYTES)
                                   && end_a != SUM_W'(CYCLE_BYTES));

    // Read position against the write position.
    always_comb
    begin
        if (alt_armed)
        begin
            pos_fault = (rhalf != p_h1)
                     || ({1'b0, snap.prime_ptr} < SUM_W'(offset))
                     || (diff_r > SUM_W'(HALF_BYTES));
            len_raw   = PTR_W'(snap.prime_ptr - PTR_W'(offset));
            flen_raw  = '0;
        end
        else
        begin
            pos_fault = (rhalf == p_h1)
                     || (snap.prime_ptr < obase)
                     || (diff_o > SUM_W'(HALF_BYTES));
            len_raw   = PTR_W'(HALF_BYTES) - PTR_W'(rho);
            flen_raw  = diff_o[PTR_W-1:0];
        end
    end

    // Clamp the two runs to one chunk and advance the offset.
    assign run_sum = len_raw + flen_raw;

    always_comb
    begin
        if (len_raw > PTR_W'(CHUNK_BYTES))
        begin
            len  = PTR_W'(CHUNK_BYTES);
            flen = '0;
        end
        else if (run_sum > PTR_W'(CHUNK_BYTES))
        begin
            len  = len_raw;
            flen = PTR_W'(CHUNK_BYTES) - len_raw;
        end
        else
        begin
            len  = len_raw;
            flen = flen_raw;
        end
    end

    assign noff   = offset + len[OFF_W-1:0] + flen[OFF_W-1:0];
    assign unread = (noff[OFF_W-1] != p_h1);

    // Choose the register write and collect all fault conditions.
    always_comb
    begin
        action = ACT_NONE;
        fault  = geom_fault || pos_fault;
        if (snap.rx_mode == MODE_OVERFLOW && snap.prime_len != '0)
        begin
            fault = 1'b1;
        end
        if (unread)
        begin
            if (alt_armed)
            begin
                fault = 1'b1;
            end
        end
        else if (snap.rx_mode == MODE_OVERFLOW)
        begin
            action = ACT_OVERFLOW;
        end
        else if (!alt_armed)
        begin
            if (snap.rx_mode != MODE_LISTEN)
            begin
                fault = 1'b1;
            end
            action = ACT_REFILL;
        end
    end

    // Assemble the result transaction and the offset update.
    always_comb
    begin
        res           = '0;
        off_upd.load  = 1'b0;
        off_upd.value = noff;
        if (snap.rx_mode == MODE_IDLE)
        begin
            res.write_action  = ACT_SETUP;
            res.new_prime_len = LEN_W'(HALF_BYTES);
            res.new_alt_ptr   = PTR_W'(HALF_BYTES);
            res.new_alt_len   = LEN_W'(HALF_BYTES);
            res.new_rx_mode   = MODE_LISTEN;
            off_upd.load      = 1'b1;
            off_upd.value     = '0;
        end
        else if (fault)
        begin
            res.snapshot_fault = 1'b1;
        end
        else
        begin
            res.read_addr    = ADDR_W'(offset);
            res.run_len      = LEN_W'(len);
            res.flip_addr    = ADDR_W'(obase);
            res.flip_len     = LEN_W'(flen);
            res.write_action = action;
            off_upd.load     = 1'b1;
            unique case (action)
                ACT_OVERFLOW:
                begin
                    res.new_prime_ptr = nbase;
                    res.new_prime_len = LEN_W'(HALF_BYTES);
                    res.new_rx_mode   = MODE_LISTEN;
                end
                ACT_REFILL:
                begin
                    res.new_alt_ptr = nbase;
                    res.new_alt_len = LEN_W'(HALF_BYTES);
                end
                default:
                begin
                    res.new_rx_mode = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/ping_pong_rx_drain_control.sv @@
// The input register captures each accepted snapshot; the result register loads the
// result computed from it whenever free. Throughput: one snapshot per cycle while
// results are taken; the read offset is updated as each non-faulting snapshot leaves
// the input register, so back-to-back snapshots see the updated offset.
// Reset (rst_n low, asynchronous) empties both stages and clears the read offset.
`default_nettype none

module ping_pong_rx_drain_control (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   snap_valid,
    output logic                   snap_ready,
    input  ppdrain_pkg::rx_snap_t  snap,
    output logic                   res_valid,
    input  logic                   res_ready,
    output ppdrain_pkg::drain_res_t res
);
    import ppdrain_pkg::*;

    logic             snap_valid_reg;
    logic             snap_valid_next;
    rx_snap_t         snap_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    drain_res_t       res_reg;
    drain_res_t       res_calc;
    logic [OFF_W-1:0] offset_reg;
    logic [OFF_W-1:0] offset_next;
    off_upd_t         off_upd;
    logic             res_free;
    logic             advance;

    // Handshake: the result register frees up when empty or being taken.
    assign res_free   = !res_valid_reg || res_ready;
    assign advance    = snap_valid_reg && res_free;
    assign snap_ready = !snap_valid_reg || res_free;

    assign snap_valid_next = snap_ready ? snap_valid : snap_valid_reg;
    assign res_valid_next  = res_free ? snap_valid_reg : res_valid_reg;
    assign offset_next     = (advance && off_upd.load) ? off_upd.value : offset_reg;

    // Per-snapshot drain computation.
    ppdrain_calc u_calc (
        .snap    (snap_reg),
        .offset  (offset_reg),
        .res     (res_calc),
        .off_upd (off_upd)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            offset_reg     <= '0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            res_valid_reg  <= res_valid_next;
            offset_reg     <= offset_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (snap_valid && snap_ready)
        begin
            snap_reg <= snap;
        end
        if (advance)
        begin
            res_reg <= res_calc;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import ppdrain_pkg::*;

    // Mode code 3 is not named in the package; the block handles it like listening, but a refill faults.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned RANDOM_ITEMS = 630;
    localparam int SNAP_W = $bits(rx_snap_t);

    // Scoreboard: predicts the drain result of every accepted snapshot and
    // checks the results in order.
    class drain_scoreboard;
        int unsigned drain_offset;
        drain_res_t expected_results[$];
        int errors;

        function new();
            drain_offset = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Works out the read runs and the register write-back for one snapshot,
        // advancing the read offset as the block does.
        function drain_res_t predict_drain(rx_snap_t s);
            int unsigned pptr, plen, aptr, alen, end_p, end_a;
            int unsigned off, rbase, obase, run, flip, noff, nbase;
            bit fault, p_h1, rhalf, unread;
            drain_res_t r;
            r = '0;
            fault = 1'b0;
            run = 0;
            flip = 0;
            pptr = 32'(s.prime_ptr);
            plen = 32'(s.prime_len);
            aptr = 32'(s.alt_ptr);
            alen = 32'(s.alt_len);

            // Idle clears the offset and orders a full register setup.
            if (s.rx_mode == MODE_IDLE)
            begin
                drain_offset = 0;
                r.write_action = ACT_SETUP;
                r.new_prime_len = LEN_W'(HALF_BYTES);
                r.new_alt_ptr = PTR_W'(HALF_BYTES);
                r.new_alt_len = LEN_W'(HALF_BYTES);
                r.new_rx_mode = MODE_LISTEN;
                return r;
            end

            end_p = pptr + plen;
            end_a = aptr + alen;
            p_h1 = (end_p == CYCLE_BYTES);
            off = drain_offset % CYCLE_BYTES;
            rhalf = (off >= HALF_BYTES);
            rbase = rhalf ? HALF_BYTES : 0;
            obase = rhalf ? 0 : HALF_BYTES;
            nbase = p_h1 ? 0 : HALF_BYTES;

            // The prime end and any armed alternate end must sit on a half boundary and must differ.
            if (end_p != HALF_BYTES && end_p != CYCLE_BYTES)
                fault = 1'b1;
            if (end_p == end_a)
                fault = 1'b1;
            if (end_a != 0 && end_a != HALF_BYTES && end_a != CYCLE_BYTES)
                fault = 1'b1;

            // Read runs depend on whether an alternate region is armed.
            if (!fault)
            begin
                if (end_a == 0)
                begin
                    if (rhalf == p_h1)
                        fault = 1'b1;
                    else if (pptr < obase || pptr - obase > HALF_BYTES)
                        fault = 1'b1;
                    else
                    begin
                        run = HALF_BYTES - (off - rbase);
                        flip = pptr - obase;
                    end
                end
                else
                begin
                    if (rhalf != p_h1)
                        fault = 1'b1;
                    else if (pptr < off || pptr - rbase > HALF_BYTES)
                        fault = 1'b1;
                    else
                        run = pptr - off;
                end
            end

            // Clamp to one chunk, then choose the register write.
            if (!fault)
            begin
                if (run > CHUNK_BYTES)
                begin
                    run = CHUNK_BYTES;
                    flip = 0;
                end
                else if (run + flip > CHUNK_BYTES)
                    flip = CHUNK_BYTES - run;
                noff = (off + run + flip) % CYCLE_BYTES;
                if (s.rx_mode == MODE_OVERFLOW && plen != 0)
                    fault = 1'b1;
                unread = ((noff >= HALF_BYTES) != p_h1);
                if (unread)
                begin
                    if (end_a != 0)
                        fault = 1'b1;
                end
                else if (s.rx_mode == MODE_OVERFLOW)
                begin
                    r.write_action = ACT_OVERFLOW;
                    r.new_prime_ptr = PTR_W'(nbase);
                    r.new_prime_len = LEN_W'(HALF_BYTES);
                    r.new_rx_mode = MODE_LISTEN;
                end
                else if (end_a == 0)
                begin
                    if (s.rx_mode != MODE_LISTEN)
                        fault = 1'b1;
                    r.write_action = ACT_REFILL;
                    r.new_alt_ptr = PTR_W'(nbase);
                    r.new_alt_len = LEN_W'(HALF_BYTES);
                end
                if (!fault)
                begin
                    drain_offset = noff;
                    r.read_addr = ADDR_W'(off);
                    r.run_len = LEN_W'(run);
                    r.flip_addr = ADDR_W'(obase);
                    r.flip_len = LEN_W'(flip);
                end
            end

            if (fault)
            begin
                r = '0;
                r.snapshot_fault = 1'b1;
            end
            return r;
        endfunction

        function void note_snapshot(rx_snap_t s);
            expected_results.push_back(predict_drain(s));
        endfunction

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_result(drain_res_t got);
            drain_res_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result %h arrived with nothing expected", got));
                return;
            end
            want = expected_results.pop_front();
            compare_field("read_addr", 16'(got.read_addr), 16'(want.read_addr));
            compare_field("run_len", 16'(got.run_len), 16'(want.run_len));
            compare_field("flip_addr", 16'(got.flip_addr), 16'(want.flip_addr));
            compare_field("flip_len", 16'(got.flip_len), 16'(want.flip_len));
            compare_field("write_action", 16'(got.write_action), 16'(want.write_action));
            compare_field("new_prime_ptr", 16'(got.new_prime_ptr), 16'(want.new_prime_ptr));
            compare_field("new_prime_len", 16'(got.new_prime_len), 16'(want.new_prime_len));
            compare_field("new_alt_ptr", 16'(got.new_alt_ptr), 16'(want.new_alt_ptr));
            compare_field("new_alt_len", 16'(got.new_alt_len), 16'(want.new_alt_len));
            compare_field("new_rx_mode", 16'(got.new_rx_mode), 16'(want.new_rx_mode));
            compare_field("snapshot_fault", 16'(got.snapshot_fault),
                          16'(want.snapshot_fault));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic snap_valid = 1'b0;
    logic snap_ready;
    rx_snap_t snap = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    drain_res_t res;

    drain_scoreboard sb = new();
    bit burst_mode = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycles = 0;

    ping_pong_rx_drain_control uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly none or short, a few long; none in burst stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (burst_mode || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Builds a consistent snapshot for the current read offset. With an alternate
    // armed, prime is the half being read; without one, prime is the other half.
    // The pick selects the prime pointer: lowest legal, highest legal or random.
    function automatic rx_snap_t make_snapshot(bit armed, logic [MODE_W-1:0] mode,
                                               int pick);
        int unsigned off, rbase, obase, lo, hi, end_a, pos, alen;
        rx_snap_t s;
        off = sb.drain_offset;
        rbase = (off >= HALF_BYTES) ? HALF_BYTES : 0;
        obase = HALF_BYTES - rbase;
        if (armed)
        begin
            lo = off;
            hi = rbase + HALF_BYTES;
            end_a = obase + HALF_BYTES;
        end
        else
        begin
            lo = obase;
            hi = obase + HALF_BYTES;
            end_a = 0;
        end
        case (pick)
            0: pos = lo;
            1: pos = hi;
            default: pos = $urandom_range(hi, lo);
        endcase
        alen = armed ? $urandom_range(HALF_BYTES, 0) : 0;
        s.prime_ptr = PTR_W'(pos);
        s.prime_len = LEN_W'(hi - pos);
        s.alt_ptr = PTR_W'(end_a - alen);
        s.alt_len = LEN_W'(alen);
        s.rx_mode = mode;
        return s;
    endfunction

    // Random snapshot: mostly consistent ones, some broken, some pure noise.
    function automatic rx_snap_t random_snapshot();
        int unsigned r, m;
        logic [MODE_W-1:0] mode;
        bit armed;
        rx_snap_t s;
        r = $urandom_range(99, 0);
        m = $urandom_range(99, 0);
        mode = (m < 70) ? MODE_LISTEN : (m < 85) ? MODE_SPARE : MODE_OVERFLOW;
        armed = 1'($urandom_range(1, 0));
        if (r < 3)
        begin
            s = rx_snap_t'(SNAP_W'({$urandom, $urandom}));
            s.rx_mode = MODE_IDLE;
            return s;
        end
        if (r < 15)
            return rx_snap_t'(SNAP_W'({$urandom, $urandom}));
        if (mode == MODE_OVERFLOW)
            s = make_snapshot(armed, mode, ($urandom_range(9, 0) < 7) ? 1 : 2);
        else
            s = make_snapshot(armed, mode,
                              (m % 10 == 0) ? 0 : (m % 10 < 3) ? 1 : 2);
        if (r < 25)
        begin
            // Break one field of an otherwise consistent snapshot.
            case ($urandom_range(4, 0))
                0: s.prime_ptr = s.prime_ptr ^ (14'd1 << $urandom_range(13, 0));
                1: s.prime_len = s.prime_len + 1'b1;
                2: s.alt_ptr = PTR_W'($urandom);
                3: s.alt_len = s.alt_len ^ (13'd1 << $urandom_range(12, 0));
                default:
                begin
                    s.prime_ptr = s.prime_ptr - 1'b1;
                    s.prime_len = s.prime_len + 1'b1;
                end
            endcase
        end
        return s;
    endfunction

    // Drives one snapshot transaction and notes it once accepted.
    task automatic send_snapshot(input rx_snap_t s);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            snap_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        snap_valid <= 1'b1;
        snap <= s;
        do
            @(posedge clk);
        while (!snap_ready);
        sb.note_snapshot(s);
    endtask

    // Result side: check each accepted result and stall at random.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res_ready <= 1'b0;
        end
        else if ($urandom_range(3, 0) == 0 && !burst_mode)
        begin
            stall_left <= pick_gap();
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        rx_snap_t s;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes: idle with all fields clear and all fields set,
        // then snapshots that fail the end checks.
        send_snapshot('{14'd0, 13'd0, 14'd0, 13'd0, MODE_IDLE});
        send_snapshot('{14'h3FFF, 13'h1FFF, 14'h3FFF, 13'h1FFF, MODE_IDLE});
        send_snapshot('{14'd0, 13'd0, 14'd0, 13'd0, MODE_LISTEN});
        send_snapshot('{14'h3FFF, 13'h1FFF, 14'h3FFF, 13'h1FFF, MODE_SPARE});
        send_snapshot('{14'd0, 13'd0, 14'd0, 13'd0, MODE_IDLE});

        // Each operation from a known offset: chunk clamp with the other half full and with it
        // empty, no-op with alternate armed, overflow reset, overflow with data left, mode three.
        send_snapshot(make_snapshot(0, MODE_LISTEN, 1));
        send_snapshot(make_snapshot(0, MODE_LISTEN, 0));
        send_snapshot(make_snapshot(1, MODE_LISTEN, 2));
        send_snapshot(make_snapshot(1, MODE_OVERFLOW, 1));
        send_snapshot(make_snapshot(0, MODE_OVERFLOW, 1));
        send_snapshot(make_snapshot(1, MODE_OVERFLOW, 0));
        send_snapshot(make_snapshot(0, MODE_SPARE, 2));
        send_snapshot(make_snapshot(1, MODE_SPARE, 2));

        // Alternate end equal to the prime end.
        s = make_snapshot(1, MODE_LISTEN, 2);
        s.alt_ptr = s.prime_ptr;
        s.alt_len = s.prime_len;
        send_snapshot(s);

        // Drain a whole half until the offset crosses and a refill is ordered,
        // then the same with mode three, where the refill faults.
        send_snapshot('{14'd0, 13'd0, 14'd0, 13'd0, MODE_IDLE});
        repeat (5) send_snapshot(make_snapshot(0, MODE_LISTEN, 1));
        repeat (4) send_snapshot(make_snapshot(0, MODE_SPARE, 1));
        send_snapshot(make_snapshot(1, MODE_LISTEN, 1));

        // Random part in stretches, some of them without any idling.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                burst_mode = ($urandom_range(3, 0) == 0);
            send_snapshot(random_snapshot());
        end
        burst_mode = 1'b0;
        snap_valid <= 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ppdrain_pkg.sv
rtl/ppdrain_calc.sv
rtl/ping_pong_rx_drain_control.sv
tb/tb.sv
